@@ design/rbcsa_pkg.sv @@
// Shared types and codes for the round-based chunk slot allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rbcsa_pkg;

  // Slot states held in the slot memory.
  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_BUSY = 2'd1,
    ST_DONE = 2'd2
  } slot_st_t;

  // Request operations.
  typedef enum logic [1:0] {
    OP_CLAIM    = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_FAIL     = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  // Response outcomes.
  typedef enum logic [2:0] {
    OC_GRANTED = 3'd0,
    OC_NOSLOT  = 3'd1,
    OC_NOMORE  = 3'd2,
    OC_IGNORED = 3'd3,
    OC_APPLIED = 3'd4
  } outcome_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_BASE_HEIGHT   = 2'd0,
    CFG_GOAL_HEIGHT   = 2'd1,
    CFG_CHUNK_SIZE    = 2'd2,
    CFG_STALL_TIMEOUT = 2'd3
  } cfg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [31:0] BASE_HEIGHT_RST   = 32'd0;
  localparam logic [31:0] GOAL_HEIGHT_RST   = 32'd0;
  localparam logic [15:0] CHUNK_SIZE_RST    = 16'd1;
  localparam logic [31:0] STALL_TIMEOUT_RST = 32'd10000;

  // Kinds of slot memory update the controller can request.
  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,
    WR_GRANT = 3'd1,
    WR_DONE  = 3'd2,
    WR_FAIL  = 3'd3,
    WR_TICK  = 3'd4
  } wr_kind_t;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_CLM_PRIME,
    S_CLM_SCAN,
    S_NOFREE,
    S_GR_ID,
    S_GR_MUL,
    S_GR_ADD,
    S_GR_FIN,
    S_CF_MATCH,
    S_CF_RD,
    S_CF_UPD,
    S_CF_CHK,
    S_ADV_A,
    S_ADV_B,
    S_ADV_C,
    S_TCK_PRIME,
    S_TCK_SCAN,
    S_OUT
  } state_t;

  // Configuration register set.
  typedef struct packed {
    logic [31:0] base_height;
    logic [31:0] goal_height;
    logic [15:0] chunk_size_blocks;
    logic [31:0] stall_timeout_ms;
  } cfg_t;

  // One slot memory entry.
  typedef struct packed {
    slot_st_t    st;
    logic [47:0] t;
  } slot_ent_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     idx_inc;
    logic     take_slot;
    logic     load_match;
    wr_kind_t wr;
    logic     advance;
    logic     set_oc;
    outcome_t oc;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic rd_free;
    logic rd_busy;
    logic rd_last;
    logic match;
    logic all_done;
    logic past;
    logic adv_ok;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ design/rbcsa_ctrl.sv @@
// Controller state machine of the chunk slot allocator.
// Depends on rbcsa_pkg; drives the datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps
`default_nettype none

module rbcsa_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire logic [1:0]       operation,
  input  wire rbcsa_pkg::sts_t  sts,
  output rbcsa_pkg::cmd_t       cmd
);

  rbcsa_pkg::state_t state;
  rbcsa_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbcsa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      rbcsa_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load = 1'b1;
          unique case (rbcsa_pkg::op_t'(operation))
            rbcsa_pkg::OP_CLAIM:    state_next = rbcsa_pkg::S_CLM_PRIME;
            rbcsa_pkg::OP_COMPLETE: state_next = rbcsa_pkg::S_CF_MATCH;
            rbcsa_pkg::OP_FAIL:     state_next = rbcsa_pkg::S_CF_MATCH;
            rbcsa_pkg::OP_TICK:     state_next = rbcsa_pkg::S_TCK_PRIME;
            default:                state_next = rbcsa_pkg::S_IDLE;
          endcase
        end
      end
      // Claim: walk the slots from the lowest, one per cycle.
      rbcsa_pkg::S_CLM_PRIME: begin
        cmd.idx_inc = 1'b1;
        state_next  = rbcsa_pkg::S_CLM_SCAN;
      end
      rbcsa_pkg::S_CLM_SCAN: begin
        if (sts.rd_free) begin
          cmd.take_slot = 1'b1;
          state_next    = rbcsa_pkg::S_GR_ID;
        end else if (sts.rd_last) begin
          state_next = rbcsa_pkg::S_NOFREE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      rbcsa_pkg::S_NOFREE: begin
        if (sts.all_done) begin
          state_next = rbcsa_pkg::S_ADV_A;
        end else begin
          cmd.set_oc = 1'b1;
          cmd.oc     = rbcsa_pkg::OC_NOSLOT;
          state_next = rbcsa_pkg::S_OUT;
        end
      end
      // Grant: chunk id, offset product and block range settle in turn.
      rbcsa_pkg::S_GR_ID:  state_next = rbcsa_pkg::S_GR_MUL;
      rbcsa_pkg::S_GR_MUL: state_next = rbcsa_pkg::S_GR_ADD;
      rbcsa_pkg::S_GR_ADD: state_next = rbcsa_pkg::S_GR_FIN;
      rbcsa_pkg::S_GR_FIN: begin
        cmd.wr     = rbcsa_pkg::WR_GRANT;
        cmd.set_oc = 1'b1;
        cmd.oc     = sts.past ? rbcsa_pkg::OC_NOMORE : rbcsa_pkg::OC_GRANTED;
        state_next = rbcsa_pkg::S_OUT;
      end
      // Complete and fail: check the round, then read and update the slot.
      rbcsa_pkg::S_CF_MATCH: begin
        if (sts.match) begin
          cmd.load_match = 1'b1;
          state_next     = rbcsa_pkg::S_CF_RD;
        end else begin
          cmd.set_oc = 1'b1;
          cmd.oc     = rbcsa_pkg::OC_IGNORED;
          state_next = rbcsa_pkg::S_OUT;
        end
      end
      rbcsa_pkg::S_CF_RD: state_next = rbcsa_pkg::S_CF_UPD;
      rbcsa_pkg::S_CF_UPD: begin
        cmd.set_oc = 1'b1;
        if (sts.op == rbcsa_pkg::OP_COMPLETE) begin
          cmd.wr     = rbcsa_pkg::WR_DONE;
          cmd.oc     = rbcsa_pkg::OC_APPLIED;
          state_next = rbcsa_pkg::S_CF_CHK;
        end else if (sts.rd_busy) begin
          cmd.wr     = rbcsa_pkg::WR_FAIL;
          cmd.oc     = rbcsa_pkg::OC_APPLIED;
          state_next = rbcsa_pkg::S_OUT;
        end else begin
          cmd.oc     = rbcsa_pkg::OC_IGNORED;
          state_next = rbcsa_pkg::S_OUT;
        end
      end
      rbcsa_pkg::S_CF_CHK: begin
        state_next = sts.all_done ? rbcsa_pkg::S_ADV_A : rbcsa_pkg::S_OUT;
      end
      // Round advance check: the chunk total compare is registered in m1_q and lhs_q before S_ADV_C tests it.
      rbcsa_pkg::S_ADV_A: state_next = rbcsa_pkg::S_ADV_B;
      rbcsa_pkg::S_ADV_B: state_next = rbcsa_pkg::S_ADV_C;
      rbcsa_pkg::S_ADV_C: begin
        if (sts.adv_ok) begin
          cmd.advance = 1'b1;
          state_next  = (sts.op == rbcsa_pkg::OP_CLAIM) ? rbcsa_pkg::S_CLM_PRIME
                                                        : rbcsa_pkg::S_OUT;
        end else begin
          if (sts.op == rbcsa_pkg::OP_CLAIM) begin
            cmd.set_oc = 1'b1;
            cmd.oc     = rbcsa_pkg::OC_NOMORE;
          end
          state_next = rbcsa_pkg::S_OUT;
        end
      end
      // Timeout tick: walk every slot and free the stalled ones.
      rbcsa_pkg::S_TCK_PRIME: begin
        cmd.idx_inc = 1'b1;
        state_next  = rbcsa_pkg::S_TCK_SCAN;
      end
      rbcsa_pkg::S_TCK_SCAN: begin
        cmd.wr = rbcsa_pkg::WR_TICK;
        if (sts.rd_last) begin
          cmd.set_oc = 1'b1;
          cmd.oc     = rbcsa_pkg::OC_APPLIED;
          state_next = rbcsa_pkg::S_OUT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      // Hand the word to the output register once it is free.
      rbcsa_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = rbcsa_pkg::S_IDLE;
        end
      end
      default: state_next = rbcsa_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ design/rbcsa_dp.sv @@
// Datapath of the chunk slot allocator: slot memory, counters, chunk
// arithmetic and the output register. Depends on rbcsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbcsa_dp #(
  parameter int SLOTS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rbcsa_pkg::cfg_t cfg,
  input  wire logic [1:0]      operation,
  input  wire logic [31:0]     chunk_num,
  input  wire logic [47:0]     time_ms,
  input  wire rbcsa_pkg::cmd_t cmd,
  output rbcsa_pkg::sts_t      sts,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output logic [2:0]           outcome,
  output logic [31:0]          granted_chunk,
  output logic [31:0]          first_height,
  output logic [31:0]          last_height,
  output logic [31:0]          round_now,
  output logic [4:0]           slots_busy,
  output logic [4:0]           slots_done,
  output logic [31:0]          chunks_done_total
);

  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int PBW = 32 + CW;

  // Latched request.
  rbcsa_pkg::op_t op_q;
  logic [31:0]    cid_q;
  logic [47:0]    now_q;

  // Scan and slot addressing.
  logic [CW-1:0]  idx;
  logic [IW-1:0]  rd_idx;
  logic [IW-1:0]  slot_q;
  logic [IW-1:0]  rd_addr;

  // Slot memory and its valid bits.
  rbcsa_pkg::slot_ent_t mem [SLOTS];
  logic [SLOTS-1:0]     vld;
  rbcsa_pkg::slot_ent_t rd_q;
  logic                 vld_q;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  rbcsa_pkg::slot_ent_t wr_ent;

  // Round state and counters.
  logic [CW-1:0]  busy_cnt;
  logic [CW-1:0]  done_cnt;
  logic [31:0]    round_q;
  logic [31:0]    ccount;

  // Chunk arithmetic.
  logic [15:0]    sz_eff;
  logic [PBW-1:0] prod_base;
  logic [PBW-1:0] cid_ext;
  logic [PBW-1:0] diff;
  logic [31:0]    id_q;
  logic [47:0]    off_full;
  logic [31:0]    off_q;
  logic [31:0]    bs_q;
  logic [31:0]    be_raw;
  logic [31:0]    be_clip;
  logic           past;
  logic [31:0]    m_next;
  logic [32:0]    m1_q;
  logic [31:0]    n_q;
  logic [48:0]    lhs_full;
  logic [48:0]    lhs_q;

  // Slot read decode.
  rbcsa_pkg::slot_st_t rd_st;
  logic [47:0]         rd_t;
  logic [47:0]         age;
  logic                expired;
  logic                match;

  // Result being built.
  rbcsa_pkg::outcome_t oc_q;
  logic [31:0]         res_chunk;
  logic [31:0]         res_bs;
  logic [31:0]         res_be;

  // Decode of the entry read in the previous cycle.
  assign sz_eff  = (cfg.chunk_size_blocks == 16'd0) ? 16'd1 : cfg.chunk_size_blocks;
  assign rd_addr = (idx < CW'(SLOTS)) ? idx[IW-1:0] : '0;
  assign rd_st   = vld_q ? rd_q.st : rbcsa_pkg::ST_FREE;
  assign rd_t    = vld_q ? rd_q.t : 48'd0;
  assign age     = now_q - rd_t;
  assign expired = (rd_st == rbcsa_pkg::ST_BUSY) && (rd_t != 48'd0)
                   && (age > 48'(cfg.stall_timeout_ms));

  // Round match of a named chunk without a divider: the chunk lies in
  // this round when it sits within SLOTS ids above round * SLOTS.
  assign cid_ext = PBW'(cid_q);
  assign diff    = cid_ext - prod_base;
  assign match   = (cid_ext >= prod_base) && (diff < PBW'(SLOTS));

  // Block range of the granted chunk.
  assign off_full = 48'(id_q) * 48'(sz_eff);
  assign be_raw   = bs_q + 32'(sz_eff) - 32'd1;
  assign be_clip  = (be_raw > cfg.goal_height) ? cfg.goal_height : be_raw;
  assign past     = bs_q > cfg.goal_height;

  // Advance test: (next round * SLOTS) < total chunks holds exactly when
  // (m + 1) * size does not exceed (target - start + size), m and the right side mod 2^32.
  assign m_next   = prod_base[31:0] + 32'(SLOTS);
  assign lhs_full = 49'(m1_q) * 49'(sz_eff);

  // Arithmetic pipeline; operands stay still while the controller waits.
  always_ff @(posedge clk) begin
    prod_base <= PBW'(round_q) * PBW'(SLOTS);
    id_q      <= prod_base[31:0] + 32'(slot_q);
    off_q     <= off_full[31:0];
    bs_q      <= cfg.base_height + off_q;
    m1_q      <= {1'b0, m_next} + 33'd1;
    n_q       <= cfg.goal_height - cfg.base_height + 32'(sz_eff);
    lhs_q     <= lhs_full;
  end

  // Slot memory update selection.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = slot_q;
    wr_ent.st = rbcsa_pkg::ST_FREE;
    wr_ent.t  = now_q;
    unique case (cmd.wr)
      rbcsa_pkg::WR_NONE: wr_en = 1'b0;
      rbcsa_pkg::WR_GRANT: begin
        wr_en     = 1'b1;
        wr_ent.st = past ? rbcsa_pkg::ST_DONE : rbcsa_pkg::ST_BUSY;
      end
      rbcsa_pkg::WR_DONE: begin
        wr_en     = 1'b1;
        wr_ent.st = rbcsa_pkg::ST_DONE;
      end
      rbcsa_pkg::WR_FAIL: wr_en = 1'b1;
      rbcsa_pkg::WR_TICK: begin
        wr_en   = expired;
        wr_addr = rd_idx;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Slot memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ent;
    end
    rd_q   <= mem[rd_addr];
    vld_q  <= vld[rd_addr];
    rd_idx <= rd_addr;
  end

  // Valid bits: an entry never written since reset or the last advance
  // reads as a free slot with a zero claim time.
  always_ff @(posedge clk) begin
    if (rst || cmd.advance) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Scan index and selected slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.load || cmd.advance) begin
      idx <= '0;
    end else if (cmd.load_match) begin
      idx <= CW'(diff[IW-1:0]);
    end else if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_slot) begin
      slot_q <= rd_idx;
    end else if (cmd.load_match) begin
      slot_q <= diff[IW-1:0];
    end
  end

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= rbcsa_pkg::op_t'(operation);
      cid_q <= chunk_num;
      now_q <= time_ms;
    end
  end

  // Round number, slot counts and completion count.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_cnt <= '0;
      done_cnt <= '0;
      round_q  <= '0;
      ccount   <= '0;
    end else if (cmd.advance) begin
      busy_cnt <= '0;
      done_cnt <= '0;
      round_q  <= round_q + 32'd1;
    end else begin
      unique case (cmd.wr)
        rbcsa_pkg::WR_GRANT: begin
          if (past) begin
            done_cnt <= done_cnt + CW'(1);
          end else begin
            busy_cnt <= busy_cnt + CW'(1);
          end
        end
        rbcsa_pkg::WR_DONE: begin
          ccount <= ccount + 32'd1;
          if (rd_st == rbcsa_pkg::ST_BUSY) begin
            busy_cnt <= busy_cnt - CW'(1);
            done_cnt <= done_cnt + CW'(1);
          end else if (rd_st == rbcsa_pkg::ST_FREE) begin
            done_cnt <= done_cnt + CW'(1);
          end
        end
        rbcsa_pkg::WR_FAIL: busy_cnt <= busy_cnt - CW'(1);
        rbcsa_pkg::WR_TICK: begin
          if (expired) begin
            busy_cnt <= busy_cnt - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Result fields of the operation in flight.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      oc_q      <= rbcsa_pkg::OC_IGNORED;
      res_chunk <= '0;
      res_bs    <= '0;
      res_be    <= '0;
    end else begin
      if (cmd.set_oc) begin
        oc_q <= cmd.oc;
      end
      if (cmd.wr == rbcsa_pkg::WR_GRANT && !past) begin
        res_chunk <= id_q;
        res_bs    <= bs_q;
        res_be    <= be_clip;
      end
    end
  end

  // Output register; it frees up in the same cycle its word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      outcome           <= oc_q;
      granted_chunk     <= res_chunk;
      first_height      <= res_bs;
      last_height       <= res_be;
      round_now         <= round_q;
      slots_busy        <= 5'(busy_cnt);
      slots_done        <= 5'(done_cnt);
      chunks_done_total <= ccount;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.op       = op_q;
    sts.rd_free  = (rd_st == rbcsa_pkg::ST_FREE);
    sts.rd_busy  = (rd_st == rbcsa_pkg::ST_BUSY);
    sts.rd_last  = (rd_idx == IW'(SLOTS - 1));
    sts.match    = match;
    sts.all_done = (done_cnt == CW'(SLOTS));
    sts.past     = past;
    sts.adv_ok   = (lhs_q <= 49'(n_q));
    sts.out_free = !rsp_valid || rsp_ready;
  end

`ifndef SYNTHESIS
  // Busy and completed slots never outnumber the slots of a round.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ((CW+1)'(busy_cnt) + (CW+1)'(done_cnt)) <= (CW+1)'(SLOTS))
    else $error("slot counts exceed the round size");

  // A round advance clears both counts and steps the round by one.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |=> (busy_cnt == '0) && (done_cnt == '0)
                    && (round_q == $past(round_q) + 32'd1))
    else $error("round advance left stale state");

  // The output register is never overwritten while it holds an untaken word.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || rsp_ready))
    else $error("response word overwritten");

  // The completion count moves only on an accepted completion.
  a_ccount: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(cmd.wr) != rbcsa_pkg::WR_DONE) |-> (ccount == $past(ccount)))
    else $error("completion count changed without a completion");
`endif

endmodule

`default_nettype wire

@@ design/round_based_chunk_slot_allocator.sv @@
// Channel   Handshake              Word
// cfg       cfg_wr_en              cfg_index, cfg_data (no wait, no read-back)
// request   req_valid / req_ready  operation, chunk_num, time_ms
// response  rsp_valid / rsp_ready  outcome, granted_chunk, first_height, last_height,
//                                  round_now, slots_busy, slots_done,
//                                  chunks_done_total
//
// One request at a time. A claim takes the lowest free slot, reports none free,
// or, with every slot done, advances the round and claims again or finds nothing
// left; complete or fail updates the named slot of this round, and a timeout tick
// frees stalled slots. The slot scan, one slot memory read per cycle, paces
// claims and ticks.
// Reset is synchronous; slot memory is cleared through valid bits, with no
// clearing pass. A held response does not stall acceptance of the next request.
// Top level; depends on rbcsa_pkg, rbcsa_ctrl and rbcsa_dp.
`timescale 1ns / 1ps
`default_nettype none

module round_based_chunk_slot_allocator #(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] chunk_num,
  input  wire logic [47:0] time_ms,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output logic [2:0]       outcome,
  output logic [31:0]      granted_chunk,
  output logic [31:0]      first_height,
  output logic [31:0]      last_height,
  output logic [31:0]      round_now,
  output logic [4:0]       slots_busy,
  output logic [4:0]       slots_done,
  output logic [31:0]      chunks_done_total
);

  rbcsa_pkg::cfg_t cfg;
  rbcsa_pkg::cmd_t cmd;
  rbcsa_pkg::sts_t sts;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_height       <= rbcsa_pkg::BASE_HEIGHT_RST;
      cfg.goal_height       <= rbcsa_pkg::GOAL_HEIGHT_RST;
      cfg.chunk_size_blocks <= rbcsa_pkg::CHUNK_SIZE_RST;
      cfg.stall_timeout_ms  <= rbcsa_pkg::STALL_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      unique case (rbcsa_pkg::cfg_idx_t'(cfg_index))
        rbcsa_pkg::CFG_BASE_HEIGHT:   cfg.base_height       <= cfg_data;
        rbcsa_pkg::CFG_GOAL_HEIGHT:   cfg.goal_height       <= cfg_data;
        rbcsa_pkg::CFG_CHUNK_SIZE:    cfg.chunk_size_blocks <= cfg_data[15:0];
        rbcsa_pkg::CFG_STALL_TIMEOUT: cfg.stall_timeout_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Controller.
  rbcsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .operation (operation),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  rbcsa_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .operation         (operation),
    .chunk_num         (chunk_num),
    .time_ms           (time_ms),
    .cmd               (cmd),
    .sts               (sts),
    .rsp_valid         (rsp_valid),
    .rsp_ready         (rsp_ready),
    .outcome           (outcome),
    .granted_chunk     (granted_chunk),
    .first_height      (first_height),
    .last_height       (last_height),
    .round_now         (round_now),
    .slots_busy        (slots_busy),
    .slots_done        (slots_done),
    .chunks_done_total (chunks_done_total)
  );

endmodule

`default_nettype wire
